>>> hdl/nal_pkg.sv
// ----------------------------------------------------------------------------
// nal_pkg: shared types and codes for the neighborhood autotile lookup
// Item layouts, opcodes, register indexes and the rule table write bundle.
// ----------------------------------------------------------------------------
package nal_pkg;

   localparam logic [2:0] OP_CELL    = 3'd0;
   localparam logic [2:0] OP_DRAIN   = 3'd1;
   localparam logic [2:0] OP_WR_CASE = 3'd2;
   localparam logic [2:0] OP_WR_CONN = 3'd3;
   localparam logic [2:0] OP_WR_TYPE = 3'd4;

   localparam logic [2:0] CSR_GRID_WIDTH     = 3'd0;
   localparam logic [2:0] CSR_GRID_HEIGHT    = 3'd1;
   localparam logic [2:0] CSR_DEFAULT_INPUT  = 3'd2;
   localparam logic [2:0] CSR_DEFAULT_OUTPUT = 3'd3;
   localparam logic [2:0] CSR_NUM_RULE_TYPES = 3'd4;

   localparam int MAX_HEIGHT = 1024;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  cell_type;
      logic [7:0]  case_mask;
      logic [7:0]  neighbor_type;
      logic [15:0] tile_value;
      logic        write_flag;
   } req_type;

   typedef struct packed {
      logic [15:0] tile;
      logic [9:0]  out_col;
      logic [9:0]  out_row;
      logic        frame_last;
   } rsp_type;

   // table write bundle from the stream side to the rule tables
   typedef struct packed {
      logic        en;
      logic [2:0]  opcode;
      logic [7:0]  rule_type;
      logic [7:0]  case_mask;
      logic [7:0]  neighbor_type;
      logic [15:0] tile_value;
      logic        write_flag;
   } tbl_wr_type;

   // position facts of the center cell carried down the pipeline
   typedef struct packed {
      logic       res;
      logic [9:0] out_col;
      logic [9:0] out_row;
      logic       last;
      logic       edge_l;
      logic       edge_r;
      logic       edge_t;
      logic       edge_b;
   } cell_pos_type;

endpackage

>>> hdl/neighborhood_autotile_lookup.sv
// ----------------------------------------------------------------------------
// neighborhood_autotile_lookup: 8-neighbor bitmask autotiler
// Raster stream of cell types in, one tile per grid cell out, chosen from
// per-type case tables by the mask of connecting neighbors.
// ----------------------------------------------------------------------------
//   port group   dir   handshake            carries
//   req_*        in    req_valid/req_ready  cells, drains, table writes
//   rsp_*        out   rsp_valid/rsp_ready  tile, column, row, frame_last
//   csr_*        in    csr_write            geometry, defaults, rule count
//
// One cell or drain item per clock while not busy and stage A is free; a tile
// leaves after the item that completes its window, via line store read, window,
// connect read, case read and output register. Table writes wait until the four
// inner stages are empty. Rule table entries, RULE_TYPES*256 rounded up to a
// power of two, are swept clear after reset; no item is taken during the sweep.
// Each stage moves when the one after it is free, so bubbles close up.
// ----------------------------------------------------------------------------
module neighborhood_autotile_lookup import nal_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int RULE_TYPES = 16,
   parameter int TYPE_BITS  = 8,
   parameter int TILE_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int WB       = $clog2(MAX_WIDTH + 1);
   localparam int CW       = (WB > 11) ? WB : 11;

   // configuration
   logic [10:0] width_ff, height_ff;
   logic [7:0]  dflt_in_ff;
   logic [15:0] dflt_out_ff;
   logic [4:0]  nrule_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 11'd1;
         height_ff   <= 11'd1;
         dflt_in_ff  <= '0;
         dflt_out_ff <= '0;
         nrule_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:     width_ff    <= csr_wdata[10:0];
            CSR_GRID_HEIGHT:    height_ff   <= csr_wdata[10:0];
            CSR_DEFAULT_INPUT:  dflt_in_ff  <= csr_wdata[7:0];
            CSR_DEFAULT_OUTPUT: dflt_out_ff <= csr_wdata;
            CSR_NUM_RULE_TYPES: nrule_ff    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] gw;
   logic [WB-1:0] w_eff;
   logic [10:0]   h_eff;
   logic [6:0]    nr;

   assign gw = CW'(width_ff);

   always_comb begin
      priority if (gw == '0) begin
         w_eff = WB'(1);
      end else if (gw > CW'(MAX_WIDTH)) begin
         w_eff = WB'(MAX_WIDTH);
      end else begin
         w_eff = WB'(gw);
      end
      priority if (height_ff == '0) begin
         h_eff = 11'd1;
      end else if (height_ff > 11'(MAX_HEIGHT)) begin
         h_eff = 11'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      nr = (7'(nrule_ff) > 7'(RULE_TYPES)) ? 7'(RULE_TYPES) : 7'(nrule_ff);
   end

   // pipeline control
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, rsp_valid_ff;
   logic a_free, b_free, c_free, d_free, out_free;
   logic a_adv, c_adv, d_adv, b_to_c;
   logic busy, pipe_empty, take, pix_take, wr_take, is_pix;
   cell_pos_type a_pos_ff, b_pos_ff, c_pos_ff, d_pos_ff, pos_in;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign d_adv    = d_valid_ff && out_free;
   assign d_free   = !d_valid_ff || out_free;
   assign c_adv    = c_valid_ff && d_free;
   assign c_free   = !c_valid_ff || d_free;
   assign b_free   = !b_valid_ff || c_free || !b_pos_ff.res;
   assign b_to_c   = b_valid_ff && b_pos_ff.res && c_free;
   assign a_adv    = a_valid_ff && b_free;
   assign a_free   = !a_valid_ff || b_free;
   assign pipe_empty = !a_valid_ff && !b_valid_ff && !c_valid_ff && !d_valid_ff;

   always_comb begin
      is_pix = 1'b0;
      unique case (req_data.opcode)
         OP_CELL, OP_DRAIN: begin
            is_pix    = 1'b1;
            req_ready = !busy && a_free;
         end
         OP_WR_CASE, OP_WR_CONN, OP_WR_TYPE: req_ready = !busy && pipe_empty;
         default: req_ready = !busy;
      endcase
   end

   assign take     = req_valid && req_ready;
   assign pix_take = take && is_pix;
   assign wr_take  = take && !is_pix;

   // scan position and center of the result
   logic [COL_BITS-1:0]  scan_col_ff, scan_col_in;
   logic [10:0]          scan_row_ff, scan_row_in;
   logic [WB-1:0]        col_ext, cc;
   logic [10:0]          cr;
   logic                 hit;
   logic [TYPE_BITS-1:0] v_in;

   assign col_ext = WB'(scan_col_ff);

   always_comb begin
      if (scan_col_ff != '0) begin
         hit = scan_row_ff != '0;
         cc  = col_ext - 1'b1;
         cr  = scan_row_ff - 1'b1;
      end else begin
         hit = scan_row_ff >= 11'd2;
         cc  = w_eff - 1'b1;
         cr  = scan_row_ff - 11'd2;
      end
      pos_in.res     = hit && (cc < w_eff) && (cr < h_eff);
      pos_in.out_col = 10'(cc);
      pos_in.out_row = 10'(cr);
      pos_in.last    = (cc == w_eff - 1'b1) && (cr == h_eff - 1'b1);
      pos_in.edge_l  = cc == '0;
      pos_in.edge_r  = cc >= w_eff - 1'b1;
      pos_in.edge_t  = cr == '0;
      pos_in.edge_b  = cr >= h_eff - 1'b1;

      // frame end wraps to the origin, row end to the next row
      priority if (scan_col_ff == '0 && 12'(scan_row_ff) >= 12'(h_eff) + 12'd1) begin
         scan_col_in = '0;
         scan_row_in = '0;
      end else if (col_ext + 1'b1 >= w_eff) begin
         scan_col_in = '0;
         scan_row_in = scan_row_ff + 1'b1;
      end else begin
         scan_col_in = scan_col_ff + 1'b1;
         scan_row_in = scan_row_ff;
      end

      v_in = (req_data.opcode == OP_CELL) ? req_data.cell_type[TYPE_BITS-1:0]
                                          : dflt_in_ff[TYPE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff <= '0;
         scan_row_ff <= '0;
      end else if (pix_take) begin
         scan_col_ff <= scan_col_in;
         scan_row_ff <= scan_row_in;
      end
   end

   // stage A: line store read
   logic [TYPE_BITS-1:0] lines_top [MAX_WIDTH];
   logic [TYPE_BITS-1:0] lines_mid [MAX_WIDTH];
   logic [TYPE_BITS-1:0] a_v_ff, a_top_ff, a_mid_ff;
   logic [COL_BITS-1:0]  a_col_ff;

   always_ff @(posedge clock) begin
      if (a_adv) begin
         lines_top[a_col_ff] <= a_mid_ff;
         lines_mid[a_col_ff] <= a_v_ff;
      end
      if (pix_take) begin
         // forward the column being written this cycle
         if (a_adv && a_col_ff == scan_col_ff) begin
            a_top_ff <= a_mid_ff;
            a_mid_ff <= a_v_ff;
         end else begin
            a_top_ff <= lines_top[scan_col_ff];
            a_mid_ff <= lines_mid[scan_col_ff];
         end
         a_v_ff   <= v_in;
         a_col_ff <= scan_col_ff;
         a_pos_ff <= pos_in;
      end
   end

   // stage B: window
   logic [TYPE_BITS-1:0] win_ff [9];
   logic [TYPE_BITS-1:0] nb [8];
   logic [TYPE_BITS-1:0] dflt_t;
   logic                 nb_out [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (a_adv) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]   <= win_ff[r*3+1];
            win_ff[r*3+1] <= win_ff[r*3+2];
         end
         win_ff[2] <= a_top_ff;
         win_ff[5] <= a_mid_ff;
         win_ff[8] <= a_v_ff;
      end
   end

   assign dflt_t = dflt_in_ff[TYPE_BITS-1:0];

   always_comb begin
      nb_out[0] = b_pos_ff.edge_l || b_pos_ff.edge_t;
      nb_out[1] = b_pos_ff.edge_t;
      nb_out[2] = b_pos_ff.edge_r || b_pos_ff.edge_t;
      nb_out[3] = b_pos_ff.edge_l;
      nb_out[4] = b_pos_ff.edge_r;
      nb_out[5] = b_pos_ff.edge_l || b_pos_ff.edge_b;
      nb_out[6] = b_pos_ff.edge_b;
      nb_out[7] = b_pos_ff.edge_r || b_pos_ff.edge_b;
      nb[0] = nb_out[0] ? dflt_t : win_ff[0];
      nb[1] = nb_out[1] ? dflt_t : win_ff[1];
      nb[2] = nb_out[2] ? dflt_t : win_ff[2];
      nb[3] = nb_out[3] ? dflt_t : win_ff[3];
      nb[4] = nb_out[4] ? dflt_t : win_ff[5];
      nb[5] = nb_out[5] ? dflt_t : win_ff[6];
      nb[6] = nb_out[6] ? dflt_t : win_ff[7];
      nb[7] = nb_out[7] ? dflt_t : win_ff[8];
   end

   // stages C and D: connect read, case read
   logic [TYPE_BITS-1:0] c_t_ff, d_t_ff;
   logic [7:0]           mask;
   logic [TILE_BITS-1:0] case_tile, type_tile, sel_tile;
   logic                 case_hit, type_cases;
   tbl_wr_type           tbl_wr;

   always_ff @(posedge clock) begin
      if (a_adv) begin
         b_pos_ff <= a_pos_ff;
      end
      if (b_to_c) begin
         c_pos_ff <= b_pos_ff;
         c_t_ff   <= win_ff[4];
      end
      if (c_adv) begin
         d_pos_ff <= c_pos_ff;
         d_t_ff   <= c_t_ff;
      end
   end

   always_comb begin
      tbl_wr.en            = wr_take;
      tbl_wr.opcode        = req_data.opcode;
      tbl_wr.rule_type     = req_data.cell_type;
      tbl_wr.case_mask     = req_data.case_mask;
      tbl_wr.neighbor_type = req_data.neighbor_type;
      tbl_wr.tile_value    = req_data.tile_value;
      tbl_wr.write_flag    = req_data.write_flag;
   end

   nal_rules #(
      .RULE_TYPES (RULE_TYPES),
      .TYPE_BITS  (TYPE_BITS),
      .TILE_BITS  (TILE_BITS)
   ) u_rules (
      .clock        (clock),
      .reset        (reset),
      .wr           (tbl_wr),
      .conn_rd_en   (b_to_c),
      .conn_type    (win_ff[4]),
      .conn_nb      (nb),
      .mask_ff      (mask),
      .case_rd_en   (c_adv),
      .case_type    (c_t_ff),
      .case_mask    (mask),
      .case_tile_ff (case_tile),
      .case_hit_ff  (case_hit),
      .type_sel     (d_t_ff),
      .type_tile    (type_tile),
      .type_cases   (type_cases),
      .busy         (busy)
   );

   always_comb begin
      priority if (9'(d_t_ff) >= 9'(nr)) begin
         sel_tile = TILE_BITS'(dflt_out_ff);
      end else if (type_cases && case_hit) begin
         sel_tile = case_tile;
      end else begin
         sel_tile = type_tile;
      end
   end

   // valid bits and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_valid_ff <= pix_take;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_free) begin
            c_valid_ff <= b_valid_ff && b_pos_ff.res;
         end
         if (d_free) begin
            d_valid_ff <= c_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (d_adv) begin
         rsp_data.tile       <= 16'(sel_tile);
         rsp_data.out_col    <= d_pos_ff.out_col;
         rsp_data.out_row    <= d_pos_ff.out_row;
         rsp_data.frame_last <= d_pos_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/nal_rules.sv
// ----------------------------------------------------------------------------
// nal_rules: rule tables of the autotile lookup
// Connection bits (eight read copies), case tiles, type defaults, and the
// clearing sweep that runs after reset.
// ----------------------------------------------------------------------------
module nal_rules import nal_pkg::*; #(
   parameter int RULE_TYPES = 16,
   parameter int TYPE_BITS  = 8,
   parameter int TILE_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tbl_wr_type           wr,
   input  logic                 conn_rd_en,
   input  logic [TYPE_BITS-1:0] conn_type,
   input  logic [TYPE_BITS-1:0] conn_nb [8],
   output logic [7:0]           mask_ff,
   input  logic                 case_rd_en,
   input  logic [TYPE_BITS-1:0] case_type,
   input  logic [7:0]           case_mask,
   output logic [TILE_BITS-1:0] case_tile_ff,
   output logic                 case_hit_ff,
   input  logic [TYPE_BITS-1:0] type_sel,
   output logic [TILE_BITS-1:0] type_tile,
   output logic                 type_cases,
   output logic                 busy
);

   localparam int RB         = (RULE_TYPES > 1) ? $clog2(RULE_TYPES) : 1;
   localparam int CONN_AW    = RB + TYPE_BITS;
   localparam int CASE_AW    = RB + 8;
   localparam int CONN_DEPTH = 1 << CONN_AW;
   localparam int CASE_DEPTH = 1 << CASE_AW;
   localparam int TYPE_DEPTH = 1 << RB;

   logic [CASE_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic               clr_active_ff, clr_active_in;

   logic [7:0]         conn_t8, case_t8, sel_t8;
   logic               rt_ok, nt_ok;
   logic               conn_we, case_we, type_we;
   logic [CONN_AW-1:0] conn_wa;
   logic               conn_wd;
   logic [CASE_AW-1:0] case_wa;
   logic [TILE_BITS:0] case_wd;

   logic [TILE_BITS-1:0] type_tile_ff [TYPE_DEPTH];
   logic                 type_cases_ff [TYPE_DEPTH];
   logic [TILE_BITS:0]   case_mem [CASE_DEPTH];

   assign busy    = clr_active_ff;
   assign conn_t8 = 8'(conn_type);
   assign case_t8 = 8'(case_type);
   assign sel_t8  = 8'(type_sel);
   assign rt_ok   = wr.rule_type < 8'(RULE_TYPES);
   assign nt_ok   = 9'(wr.neighbor_type) < 9'(1 << TYPE_BITS);

   always_comb begin
      clr_cnt_in    = clr_cnt_ff + 1'b1;
      clr_active_in = clr_active_ff && (clr_cnt_ff != '1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         clr_active_ff <= 1'b1;
      end else if (clr_active_ff) begin
         clr_cnt_ff    <= clr_cnt_in;
         clr_active_ff <= clr_active_in;
      end
   end

   // write port muxing: the sweep owns the memories until it is done
   always_comb begin
      if (clr_active_ff) begin
         conn_we = 1'b1;
         conn_wa = {clr_cnt_ff[CASE_AW-1:8], clr_cnt_ff[TYPE_BITS-1:0]};
         conn_wd = 1'b0;
         case_we = 1'b1;
         case_wa = clr_cnt_ff;
         case_wd = '0;
      end else begin
         conn_we = wr.en && (wr.opcode == OP_WR_CONN) && rt_ok && nt_ok;
         conn_wa = {wr.rule_type[RB-1:0], wr.neighbor_type[TYPE_BITS-1:0]};
         conn_wd = wr.write_flag;
         case_we = wr.en && (wr.opcode == OP_WR_CASE) && rt_ok;
         case_wa = {wr.rule_type[RB-1:0], wr.case_mask};
         case_wd = {wr.write_flag, TILE_BITS'(wr.tile_value)};
      end
   end

   assign type_we = wr.en && (wr.opcode == OP_WR_TYPE) && rt_ok && !clr_active_ff;

   for (genvar k = 0; k < 8; k++) begin : g_conn
      logic conn_mem [CONN_DEPTH];

      always_ff @(posedge clock) begin
         if (conn_we) begin
            conn_mem[conn_wa] <= conn_wd;
         end
         // neighbor k lands on mask bit 7-k
         if (conn_rd_en) begin
            mask_ff[7-k] <= conn_mem[{conn_t8[RB-1:0], conn_nb[k]}];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (case_we) begin
         case_mem[case_wa] <= case_wd;
      end
      if (case_rd_en) begin
         {case_hit_ff, case_tile_ff} <= case_mem[{case_t8[RB-1:0], case_mask}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TYPE_DEPTH; i++) begin
            type_tile_ff[i]  <= '0;
            type_cases_ff[i] <= 1'b0;
         end
      end else begin
         if (type_we) begin
            type_tile_ff[wr.rule_type[RB-1:0]] <= TILE_BITS'(wr.tile_value);
         end
         if (case_we && !clr_active_ff && wr.write_flag) begin
            type_cases_ff[wr.rule_type[RB-1:0]] <= 1'b1;
         end
      end
   end

   assign type_tile  = type_tile_ff[sel_t8[RB-1:0]];
   assign type_cases = type_cases_ff[sel_t8[RB-1:0]];

endmodule
